@@ hw/rtl/fcpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fcpu_pkg;

  localparam int QuarterN = 256;
  localparam int FullTurn = 46080;
  localparam int QuarterTurn = 11520;
  localparam logic [20:0] StepReset = 21'd19661;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_LOOKUP,
    ST_MUL_A,
    ST_MUL_B,
    ST_MOVE_FB,
    ST_MOVE_LR,
    ST_ROT,
    ST_OUT
  } fcpu_state_t;

  typedef struct packed {
    logic load;
    logic angle;
    logic lookup;
    logic mul_a;
    logic mul_b;
    logic move_fb;
    logic move_lr;
    logic rot;
    logic clear_dirty;
  } fcpu_status_unused_t;

  typedef struct packed {
    logic load;
    logic angle;
    logic lookup;
    logic mul_a;
    logic mul_b;
    logic move_fb;
    logic move_lr;
    logic rot;
    logic clear_dirty;
  } fcpu_cmd_t;

  typedef struct packed {
    logic dirty;
  } fcpu_status_t;

  typedef logic [14:0] qsine_tab_t [QuarterN + 1];

  // Quarter-wave sine, Q1.14, 257 entries; Taylor series in Q30 from a Q30 pi
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t t;
    longint unsigned x, x2, term;
    longint sum;
    for (int i = 0; i <= QuarterN; i++) begin
      x = (64'd3373259426 * 64'(i)) / 64'd512;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      t[i] = 15'((sum + 64'sd32768) >>> 16);
    end
    return t;
  endfunction

  localparam qsine_tab_t QSine = build_qsine();

  function automatic logic signed [15:0] sine_at(input logic [9:0] idx);
    logic [1:0] q;
    logic [7:0] r;
    logic [14:0] m;
    q = idx[9:8];
    r = idx[7:0];
    if (q[0]) m = QSine[9'(QuarterN) - {1'b0, r}];
    else m = QSine[{1'b0, r}];
    if (q[1]) return -$signed({1'b0, m});
    return $signed({1'b0, m});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] rshift(input logic signed [55:0] v,
                                                input logic [4:0] s);
    logic [55:0] a;
    logic [55:0] half;
    half = 56'd1 << (s - 5'd1);
    if (!v[55]) begin
      a = (v + half) >> s;
    end else begin
      a = -v;
      a = (a + half) >> s;
      a = -a;
    end
    return a[47:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fcpu_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fcpu_ctrl
  import fcpu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_fire,
  input  wire logic         out_free,
  input  wire fcpu_status_t status,
  output fcpu_cmd_t         cmd,
  output logic              busy,
  output logic              out_load
);

  fcpu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_fire) state_next = ST_ANGLE;
      ST_ANGLE:   state_next = ST_LOOKUP;
      ST_LOOKUP:  state_next = ST_MUL_A;
      ST_MUL_A:   state_next = ST_MUL_B;
      ST_MUL_B:   state_next = ST_MOVE_FB;
      ST_MOVE_FB: state_next = ST_MOVE_LR;
      ST_MOVE_LR: state_next = ST_ROT;
      ST_ROT:     state_next = status.dirty ? ST_OUT : ST_IDLE;
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      ST_ANGLE:   cmd.angle = 1'b1;
      ST_LOOKUP:  cmd.lookup = 1'b1;
      ST_MUL_A:   cmd.mul_a = 1'b1;
      ST_MUL_B:   cmd.mul_b = 1'b1;
      ST_MOVE_FB: cmd.move_fb = 1'b1;
      ST_MOVE_LR: cmd.move_lr = 1'b1;
      ST_ROT:     cmd.rot = 1'b1;
      ST_OUT: begin
        out_load = out_free;
        cmd.clear_dirty = out_free;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/fcpu_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fcpu_datapath
  import fcpu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fcpu_cmd_t           cmd,
  input  wire logic [35:0]         in_data,
  input  wire logic [20:0]         step_distance,
  output fcpu_status_t             status,
  output logic        [239:0]      pose
);

  logic signed [14:0] pd;
  logic signed [16:0] yd;
  logic fwd, back, left, right;
  logic signed [14:0] pitch;
  logic [15:0] yaw;
  logic dirty;
  logic signed [31:0] px, py, pz;
  logic signed [15:0] sp, cp, sy, cy;
  logic signed [31:0] syc, cyc;
  logic signed [47:0] ddx, ddy, ddz, dlx, dlz;
  logic signed [15:0] r01, r02, r21, r22;

  logic signed [15:0] pitch_sum;
  logic signed [17:0] yd_sat;
  logic signed [18:0] yaw_sum;
  logic [9:0] ip, iy;
  logic signed [21:0] d;
  logic signed [31:0] fx, fy, fz;
  logic signed [16:0] pitch_ofs;

  assign d = $signed({1'b0, step_distance});
  assign pitch_sum = 16'(pitch) + 16'(pd);
  assign yd_sat = (yd > 17'sd46080) ? 18'sd46080 :
                  (yd < -17'sd46080) ? -18'sd46080 : 18'(yd);
  assign yaw_sum = $signed({3'b000, yaw}) + 19'(yd_sat);
  assign pitch_ofs = 17'(pitch) + 17'sd46080;
  // index = round(angle * 1024 / 46080) with pitch offset by a full turn to stay positive
  assign ip = 10'((({17'd0, pitch_ofs[15:0], 10'd0} + 43'd23040) * 43'd93207) >> 32);
  assign iy = 10'((({17'd0, yaw, 10'd0} + 43'd23040) * 43'd93207) >> 32);

  always_comb begin
    fx = px;
    fy = py;
    fz = pz;
    if (fwd) begin
      fx = sat32(34'(fx) + 34'(ddx));
      fy = sat32(34'(fy) - 34'(ddy));
      fz = sat32(34'(fz) - 34'(ddz));
    end
    if (back) begin
      fx = sat32(34'(fx) - 34'(ddx));
      fy = sat32(34'(fy) + 34'(ddy));
      fz = sat32(34'(fz) + 34'(ddz));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch <= '0;
      yaw <= '0;
      dirty <= 1'b1;
      px <= '0;
      py <= '0;
      pz <= '0;
    end else begin
      if (cmd.load) begin
        {right, left, back, fwd, yd, pd} <= in_data;
      end
      if (cmd.angle) begin
        if (pd != 0) begin
          dirty <= 1'b1;
          if (pitch_sum <= -16'sd11520) pitch <= -15'sd11520;
          else if (pitch_sum >= 16'sd11520) pitch <= 15'sd11520;
          else pitch <= pitch_sum[14:0];
        end
        if (yd != 0) begin
          dirty <= 1'b1;
          if (yaw_sum <= 0) yaw <= 16'(yaw_sum + 19'sd46080);
          else if (yaw_sum >= 19'sd46080) yaw <= 16'(yaw_sum - 19'sd46080);
          else yaw <= yaw_sum[15:0];
        end
      end
      if (cmd.lookup) begin
        sp <= sine_at(ip);
        cp <= sine_at(ip + 10'd256);
        sy <= sine_at(iy);
        cy <= sine_at(iy + 10'd256);
      end
      if (cmd.mul_a) begin
        syc <= sy * cp;
        cyc <= cy * cp;
        ddy <= rshift(56'(d * 38'(sp)), 5'd14);
        dlx <= rshift(56'(d * 38'(cy)), 5'd14);
        dlz <= rshift(56'(d * 38'(sy)), 5'd14);
      end
      if (cmd.mul_b) begin
        ddx <= rshift(56'(d * 54'(syc)), 5'd28);
        ddz <= rshift(56'(d * 54'(cyc)), 5'd28);
      end
      if (cmd.move_fb) begin
        px <= fx;
        py <= fy;
        pz <= fz;
        if (fwd || back) dirty <= 1'b1;
      end
      if (cmd.move_lr) begin
        if (left && !right) begin
          px <= sat32(34'(px) - 34'(dlx));
          pz <= sat32(34'(pz) - 34'(dlz));
        end else if (right && !left) begin
          px <= sat32(34'(px) + 34'(dlx));
          pz <= sat32(34'(pz) + 34'(dlz));
        end else if (left && right) begin
          px <= sat32(34'(sat32(34'(px) - 34'(dlx))) + 34'(dlx));
          pz <= sat32(34'(sat32(34'(pz) - 34'(dlz))) + 34'(dlz));
        end
        if (left || right) dirty <= 1'b1;
      end
      if (cmd.clear_dirty) dirty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rot) begin
      r01 <= 16'(rshift(56'(32'(sy) * 32'(sp)), 5'd14));
      r02 <= 16'(rshift(56'(syc), 5'd14));
      r21 <= 16'(rshift(56'(32'(cy) * 32'(sp)), 5'd14));
      r22 <= 16'(rshift(56'(cyc), 5'd14));
    end
  end

  assign status.dirty = dirty;
  assign pose = {pz, py, px, r22, r21, -sy, -sp, cp, 16'd0, r02, r01, cy};

endmodule
`default_nettype wire

@@ hw/rtl/fly_camera_pose_update.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Fly camera pose update. Each transfer on s_axis is one frame tick; when the pose
// changed (or on the first tick after reset) one transfer follows on m_axis. A tick
// goes through a fixed controller sequence (angle update, sine lookup, two multiply
// steps, two move steps, rotation products), plus the output hand-off once the result
// register is free when a pose is due; the next tick is taken after that. step_distance
// is written via cfg_valid/cfg_ready only while idle.
module fly_camera_pose_update
  import fcpu_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pitch_delta[14:0], yaw_delta[31:15], go_forward, go_back, go_left, go_right, pad
  input  wire logic [39:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // rot_00..rot_22 (16 b each), pos_x, pos_y, pos_z (32 b each)
  output logic [239:0]      m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [20:0]  cfg_data
);

  fcpu_cmd_t cmd;
  fcpu_status_t status;
  logic busy, out_load, in_fire, out_free;
  logic [20:0] step_distance;
  logic [239:0] pose;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) step_distance <= StepReset;
    else if (cfg_valid && cfg_ready) step_distance <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) m_axis_tdata <= pose;
  end

  fcpu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .status(status), .cmd(cmd), .busy(busy), .out_load(out_load)
  );

  fcpu_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_data(s_axis_tdata[35:0]),
    .step_distance(step_distance), .status(status), .pose(pose)
  );

  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    out_load |-> busy) else $error("output loaded while idle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("accept while busy");
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> !status.dirty) else $error("dirty not cleared");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import fcpu_pkg::*;

  class pose_scoreboard;
    longint quarter_sin[257];
    longint pos[3];
    longint pitch, yaw, step;
    bit dirty;
    logic [239:0] due[$];
    int errors, poses, ticks;

    function new();
      longint unsigned x, x2, term;
      longint sum;
      for (int i = 0; i <= 256; i++) begin
        x = (64'd3373259426 * i) / 512;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 12; k++) begin
          term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
          if (k % 2) sum -= longint'(term);
          else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        quarter_sin[i] = (sum + 32768) >>> 16;
      end
      pos = '{0, 0, 0};
      pitch = 0;
      yaw = 0;
      step = StepReset;
      dirty = 1;
    endfunction

    function longint sin_of(longint idx);
      longint i, r;
      i = idx % 1024;
      r = i % 256;
      case (i / 256)
        0: return quarter_sin[r];
        1: return quarter_sin[256 - r];
        2: return -quarter_sin[r];
        default: return -quarter_sin[256 - r];
      endcase
    endfunction

    function longint turn_index(longint a);
      return ((a + 2 * FullTurn) * 1024 + FullTurn / 2) / FullTurn;
    endfunction

    function longint rnd(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_tick(logic [39:0] d);
      longint pd, yd, sp, cp, sy, cy, syc, cyc, dx, dy, dz;
      logic [239:0] w;
      pd = longint'($signed(d[14:0]));
      yd = longint'($signed(d[31:15]));
      ticks++;
      if (pd != 0) begin
        pitch += pd;
        if (pitch <= -QuarterTurn) pitch = -QuarterTurn;
        else if (pitch >= QuarterTurn) pitch = QuarterTurn;
        dirty = 1;
      end
      if (yd != 0) begin
        if (yd > FullTurn) yd = FullTurn;
        if (yd < -FullTurn) yd = -FullTurn;
        yaw += yd;
        if (yaw <= 0) yaw += FullTurn;
        else if (yaw >= FullTurn) yaw -= FullTurn;
        dirty = 1;
      end
      sp = sin_of(turn_index(pitch));
      cp = sin_of(turn_index(pitch) + QuarterN);
      sy = sin_of(turn_index(yaw));
      cy = sin_of(turn_index(yaw) + QuarterN);
      syc = sy * cp;
      cyc = cy * cp;
      if (d[32] || d[33]) begin
        dx = rnd(step * syc, 28);
        dy = rnd(step * sp, 14);
        dz = rnd(step * cyc, 28);
        if (d[32]) begin
          pos[0] = sat(pos[0] + dx);
          pos[1] = sat(pos[1] - dy);
          pos[2] = sat(pos[2] - dz);
        end
        if (d[33]) begin
          pos[0] = sat(pos[0] - dx);
          pos[1] = sat(pos[1] + dy);
          pos[2] = sat(pos[2] + dz);
        end
        dirty = 1;
      end
      if (d[34] || d[35]) begin
        dx = rnd(step * cy, 14);
        dz = rnd(step * sy, 14);
        if (d[34]) begin
          pos[0] = sat(pos[0] - dx);
          pos[2] = sat(pos[2] - dz);
        end
        if (d[35]) begin
          pos[0] = sat(pos[0] + dx);
          pos[2] = sat(pos[2] + dz);
        end
        dirty = 1;
      end
      if (!dirty) return;
      dirty = 0;
      w[15:0] = cy[15:0];
      w[31:16] = 16'(rnd(sy * sp, 14));
      w[47:32] = 16'(rnd(syc, 14));
      w[63:48] = '0;
      w[79:64] = cp[15:0];
      w[95:80] = 16'(-sp);
      w[111:96] = 16'(-sy);
      w[127:112] = 16'(rnd(cy * sp, 14));
      w[143:128] = 16'(rnd(cyc, 14));
      w[175:144] = pos[0][31:0];
      w[207:176] = pos[1][31:0];
      w[239:208] = pos[2][31:0];
      due.push_back(w);
    endfunction

    function void check_pose(logic [239:0] got);
      logic [239:0] exp_w;
      logic [31:0] e, g;
      if (due.size() == 0) begin
        $display("%0t: pose transfer with none pending: %h", $time, got);
        errors++;
        return;
      end
      exp_w = due.pop_front();
      poses++;
      for (int f = 0; f < 12; f++) begin
        if (f < 9) begin
          e = {16'd0, exp_w[16 * f +: 16]};
          g = {16'd0, got[16 * f +: 16]};
        end else begin
          e = exp_w[144 + 32 * (f - 9) +: 32];
          g = got[144 + 32 * (f - 9) +: 32];
        end
        if (e !== g) begin
          $display("%0t: field %0d mismatch: expected %h, actual %h", $time, f, e, g);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [239:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [20:0] cfg_data;
  bit no_gaps;
  int quiet;
  pose_scoreboard sb;

  fly_camera_pose_update DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: random stalls unless no_gaps is set
  initial begin
    int n;
    m_axis_tready = 1'b0;
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        @(negedge clk) m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_pose(m_axis_tdata);

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_tick(logic [39:0] d);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 13);
    if (n > 0) begin
      @(negedge clk) s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(d);
  endtask

  task automatic drain();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_step(logic [20:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.step = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic logic [39:0] tick(int pd, int yd, logic [3:0] moves);
    return {4'd0, moves, 17'(yd), 15'(pd)};
  endfunction

  function automatic logic [39:0] random_tick();
    int pd, yd, r;
    r = $urandom_range(0, 99);
    if (r < 25) return tick(0, 0, 4'd0);
    if (r < 35) return tick(0, 0, 4'($urandom));
    pd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 23040) - 11520
                                     : $urandom_range(0, 1024) - 512;
    yd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 92160) - 46080
                                     : $urandom_range(0, 4096) - 2048;
    if ($urandom_range(0, 3) == 0) pd = 0;
    if ($urandom_range(0, 3) == 0) yd = 0;
    return tick(pd, yd, 4'($urandom));
  endfunction

  initial begin
    logic [39:0] directed[$];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_gaps = 1'b0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    directed = '{tick(0, 0, 4'd0), tick(0, 0, 4'd0), tick(11520, 0, 4'd0),
                 tick(-11520, 0, 4'd0), tick(-11520, 0, 4'd0), tick(-11520, 0, 4'd1),
                 tick(5000, 46080, 4'd0), tick(0, -46080, 4'd0), tick(0, -1, 4'd0),
                 tick(0, 1, 4'd0), tick(0, 11520, 4'd1), tick(0, 0, 4'd2),
                 tick(0, 0, 4'd4), tick(0, 0, 4'd8), tick(0, 0, 4'hf),
                 tick(-1, 23040, 4'd3), tick(1, -23040, 4'hc), tick(0, 0, 4'd0),
                 tick(11519, 46079, 4'd5), tick(-11519, -46079, 4'ha),
                 tick(-16384, 65535, 4'd0), tick(16383, -65536, 4'd0)};
    foreach (directed[i]) send_tick(directed[i]);

    write_step(21'd0);
    repeat (198) send_tick(random_tick());
    drain();
    write_step(21'd1048576);
    no_gaps = 1'b1;
    repeat (300) send_tick(random_tick());
    no_gaps = 1'b0;
    write_step(21'($urandom_range(1, 1048575)));
    repeat (250) send_tick(random_tick());
    write_step(21'($urandom_range(0, 4096)));
    repeat (110) send_tick(random_tick());
    write_step(StepReset);
    repeat (20) send_tick(random_tick());

    drain();
    $display("Covered %0d ticks and %0d pose transfers over five step settings,",
             sb.ticks, sb.poses);
    $display("including angle clamp and wrap limits and back-to-back transfers.");
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
